// File: sv/lru_cache_key_value_store_unit_defines.svh
// Assertion macros for the LRU key/value store checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef LRU_CACHE_KEY_VALUE_STORE_UNIT_DEFINES_SVH
`define LRU_CACHE_KEY_VALUE_STORE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define LRUKV_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lrukv: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define LRUKV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lrukv: next-cycle check failed");

`endif

// File: sv/lrukv_pkg.sv
// Shared types and constants of the LRU key/value store.
// No dependencies; used by the cell, the top level and the checker.
package lrukv_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic             load;
    logic [KEY_W-1:0] cmp_key;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

endpackage

// File: sv/lru_cache_key_value_store_unit.sv
// Top level of the LRU key/value store: control, capacity register and
// the chain of lrukv_cell slots. Depends on lrukv_pkg and lrukv_cell.
//
// Usage:
//   Input channel in_*: one transaction is a get (opcode 0) or a put
//   (opcode 1) with a key and a value. Output channel out_*: one
//   transaction per get, carrying hit and the stored value (zero on miss).
//   Puts give no output transaction.
//   cfg_write_enable/cfg_write_data set the capacity limit; write it only
//   while the block is idle. A limit of 0 acts as 1, above ENTRIES as ENTRIES.
// Timing:
//   A new transaction is taken only once the last one has updated the chain:
//   the key is compared against every slot in the accept cycle, then the
//   chain shifts toward the least recent end in the update state, which a
//   get can stall (see Stall). A get result is registered at that update edge.
// Reset:
//   All slots become empty and the limit returns to 16; no clearing pass.
// Stall:
//   A result waits in the output register; a following get holds in its
//   update cycle until that register drains, a put proceeds.
module lru_cache_key_value_store_unit #(
  parameter int ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic signed [31:0] in_lookup_key,
  input  logic signed [31:0] in_store_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic signed [31:0] out_read_value,
  input  logic               cfg_write_enable,
  input  logic [4:0]         cfg_write_data
);

  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > lrukv_pkg::CAP_W) ? OCC_W : lrukv_pkg::CAP_W;

  lrukv_pkg::state_t state_r, state_nxt;

  logic [lrukv_pkg::CAP_W-1:0] cap_r;
  logic [OCC_W-1:0]            occ_r, occ_nxt;
  logic [ENTRIES-1:0]          match_r;
  logic [ENTRIES-1:0]          cell_match;
  logic                        op_r;
  logic [lrukv_pkg::KEY_W-1:0] key_r;
  logic [lrukv_pkg::VAL_W-1:0] value_r;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_hit_r;
  logic [lrukv_pkg::VAL_W-1:0] out_value_r;

  logic                        in_accept;
  logic                        upd_fire;
  logic                        change;
  logic                        hit;
  logic [lrukv_pkg::VAL_W-1:0] hit_value;
  logic [CMP_W-1:0]            lim_eff;
  logic                        full;

  lrukv_pkg::entry_t head_entry;
  lrukv_pkg::entry_t entries [ENTRIES];

  assign in_stall  = (state_r != lrukv_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign upd_fire  = (state_r == lrukv_pkg::ST_UPDATE) &&
                     ((op_r == lrukv_pkg::OP_PUT) || !out_valid_r || !out_stall);
  assign hit       = |match_r;
  assign change    = upd_fire && (hit || (op_r == lrukv_pkg::OP_PUT));

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_value = hit_value | (match_r[i] ? entries[i].value : '0);
    end
  end

  always_comb begin
    if (cap_r == '0) begin
      lim_eff = CMP_W'(1);
    end else if (CMP_W'(cap_r) > CMP_W'(ENTRIES)) begin
      lim_eff = CMP_W'(ENTRIES);
    end else begin
      lim_eff = CMP_W'(cap_r);
    end
  end

  assign full = (CMP_W'(occ_r) >= lim_eff);

  assign head_entry.valid = 1'b1;
  assign head_entry.key   = key_r;
  assign head_entry.value = (op_r == lrukv_pkg::OP_PUT) ? value_r : hit_value;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lrukv_pkg::cell_ctrl_t ctrl;
    lrukv_pkg::entry_t     prev_entry;

    if (i == 0) begin : g_head
      assign ctrl.load  = change;
      assign prev_entry = head_entry;
    end else begin : g_body
      assign ctrl.load  = change &&
                          (hit ? (|match_r[ENTRIES-1:i]) :
                           (full ? (OCC_W'(i) < occ_r) : (OCC_W'(i) <= occ_r)));
      assign prev_entry = entries[i-1];
    end

    assign ctrl.cmp_key = in_lookup_key;

    lrukv_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev_entry (prev_entry),
      .entry      (entries[i]),
      .match      (cell_match[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      lrukv_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_nxt = lrukv_pkg::ST_UPDATE;
        end
      end
      lrukv_pkg::ST_UPDATE: begin
        if (upd_fire) begin
          state_nxt = lrukv_pkg::ST_IDLE;
          if (op_r == lrukv_pkg::OP_GET) begin
            out_valid_nxt = 1'b1;
          end else if (!hit && !full) begin
            occ_nxt = occ_r + OCC_W'(1);
          end
        end
      end
      default: begin
        state_nxt = lrukv_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrukv_pkg::ST_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
      cap_r       <= lrukv_pkg::CAP_RESET;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write_enable) begin
        cap_r <= cfg_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      match_r <= cell_match;
      op_r    <= in_opcode;
      key_r   <= in_lookup_key;
      value_r <= in_store_value;
    end
    if (upd_fire && (op_r == lrukv_pkg::OP_GET)) begin
      out_hit_r   <= hit;
      out_value_r <= hit_value;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_value_r;

endmodule

// File: sv/lrukv_cell.sv
// One recency slot of the LRU chain: holds an entry, compares its key,
// and loads from its upstream neighbor. Depends on lrukv_pkg.
module lrukv_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  lrukv_pkg::cell_ctrl_t ctrl,
  input  lrukv_pkg::entry_t   prev_entry,
  output lrukv_pkg::entry_t   entry,
  output logic                match
);

  logic                        valid_r;
  logic [lrukv_pkg::KEY_W-1:0] key_r;
  logic [lrukv_pkg::VAL_W-1:0] value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.load) begin
      valid_r <= prev_entry.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      key_r   <= prev_entry.key;
      value_r <= prev_entry.value;
    end
  end

  assign entry.valid = valid_r;
  assign entry.key   = key_r;
  assign entry.value = value_r;
  assign match       = valid_r && (key_r == ctrl.cmp_key);

endmodule

// File: sv/lrukv_checker.sv
// Port-level checker for the LRU key/value store, bound to the top level.
// Depends on lrukv_pkg and lru_cache_key_value_store_unit_defines.svh.
`include "lru_cache_key_value_store_unit_defines.svh"

module lrukv_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_opcode,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_hit,
  input logic signed [31:0] out_read_value
);

  `LRUKV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_hit) && $stable(out_read_value))
  `LRUKV_ASSERT_SAME(a_miss_zero, clk, rst_n, out_valid && !out_hit,
    out_read_value == 32'sd0)
  `LRUKV_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `LRUKV_ASSERT_SAME(a_result_after_update, clk, rst_n, $rose(out_valid), $past(in_stall))
  `LRUKV_ASSERT_NEXT(a_put_no_result, clk, rst_n,
    in_valid && !in_stall && (in_opcode == lrukv_pkg::OP_PUT) && !out_valid,
    !out_valid ##1 !out_valid)

endmodule

bind lru_cache_key_value_store_unit lrukv_checker u_lrukv_checker (.*);

// File: tb/tb.sv
// Self-checking testbench for lru_cache_key_value_store_unit: a driver feeds get/put
// transactions, a monitor checks each get result against an LRU predictor.
// Depends on lrukv_pkg and the DUT sources.
module tb;

  localparam int SLOTS = 16;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic        op;
    logic [31:0] key;
    logic [31:0] val;
  } cache_req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] value;
  } lookup_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_opcode = lrukv_pkg::OP_GET;
  logic signed [31:0] in_lookup_key = '0;
  logic signed [31:0] in_store_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_hit;
  logic signed [31:0] out_read_value;
  logic               cfg_write_enable = 1'b0;
  logic [4:0]         cfg_write_data = lrukv_pkg::CAP_RESET;

  cache_req_t   req_queue[$];
  lookup_resp_t resp_queue[$];
  int queued_count = 0;
  int accepted_count = 0;
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  logic hold_kick = 1'b0;
  logic [31:0] key_pool[32];

  logic [31:0] slot_key[SLOTS];
  logic [31:0] slot_val[SLOTS];
  bit          slot_used[SLOTS];
  int          slot_rank[SLOTS];
  int          fill_count = 0;
  logic [4:0]  cap_limit = lrukv_pkg::CAP_RESET;

  lru_cache_key_value_store_unit #(.ENTRIES(SLOTS)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_lookup_key    (in_lookup_key),
    .in_store_value   (in_store_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_read_value   (out_read_value),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int find_slot(logic [31:0] key);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && slot_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic void promote(int e);
    int r;
    r = slot_rank[e];
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && slot_rank[i] < r) slot_rank[i]++;
    end
    slot_rank[e] = 0;
  endfunction

  function automatic int oldest_slot();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && (best < 0 || slot_rank[i] > slot_rank[best])) best = i;
    end
    return best;
  endfunction

  function automatic void apply_request(logic op, logic [31:0] key, logic [31:0] val);
    int e;
    int lim;
    lookup_resp_t r;
    e = find_slot(key);
    if (op == lrukv_pkg::OP_GET) begin
      r.hit = (e >= 0);
      r.value = (e >= 0) ? slot_val[e] : 32'd0;
      if (e >= 0) promote(e);
      resp_queue.push_back(r);
      return;
    end
    if (e >= 0) begin
      slot_val[e] = val;
      promote(e);
      return;
    end
    lim = (cap_limit == 0) ? 1 : ((cap_limit > SLOTS) ? SLOTS : int'(cap_limit));
    if (fill_count >= lim) begin
      e = oldest_slot();
      promote(e);
    end else begin
      e = 0;
      while (slot_used[e]) e++;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_used[i]) slot_rank[i]++;
      end
      slot_used[e] = 1'b1;
      slot_rank[e] = 0;
      fill_count++;
    end
    slot_key[e] = key;
    slot_val[e] = val;
  endfunction

  // driver
  always @(posedge clk) begin
    cache_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_request(in_opcode, in_lookup_key, in_store_value);
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = req_queue.pop_front();
          in_valid <= 1'b1;
          in_opcode <= nxt.op;
          in_lookup_key <= nxt.key;
          in_store_value <= nxt.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    lookup_resp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (resp_queue.size() == 0) begin
        $error("result with no get pending: hit %0b read_value %0d", out_hit, out_read_value);
        fail_count++;
      end else begin
        want = resp_queue.pop_front();
        if (out_hit !== want.hit) begin
          $error("hit: expected %0b, got %0b", want.hit, out_hit);
          fail_count++;
        end
        if (out_read_value !== want.value) begin
          $error("read_value: expected %0d, got %0d", $signed(want.value), out_read_value);
          fail_count++;
        end
      end
    end
  end

  task automatic queue_req(logic op, logic [31:0] key, logic [31:0] val);
    cache_req_t t;
    t.op = op;
    t.key = key;
    t.val = val;
    req_queue.push_back(t);
    queued_count++;
  endtask

  task automatic queue_random(int n, int pool_n);
    logic [31:0] key;
    for (int i = 0; i < 32; i++) key_pool[i] = $urandom;
    for (int i = 0; i < n; i++) begin
      key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(pool_n - 1)] : $urandom;
      queue_req($urandom_range(1) ? lrukv_pkg::OP_PUT : lrukv_pkg::OP_GET, key, $urandom);
    end
  endtask

  task automatic wait_idle();
    while (accepted_count != queued_count || resp_queue.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(logic [4:0] v);
    @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    cap_limit = v;
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_key[i] = '0;
      slot_val[i] = '0;
      slot_used[i] = 1'b0;
      slot_rank[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_req(lrukv_pkg::OP_GET, 32'h8000_0000, $urandom);
    queue_req(lrukv_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_req(lrukv_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_req(lrukv_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_req(lrukv_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_req(lrukv_pkg::OP_PUT, 32'h0000_0001, 32'h1234_5678);
    queue_req(lrukv_pkg::OP_GET, 32'h8000_0000, $urandom);
    queue_req(lrukv_pkg::OP_GET, 32'h7FFF_FFFF, $urandom);
    queue_req(lrukv_pkg::OP_GET, 32'h0000_0000, $urandom);
    queue_req(lrukv_pkg::OP_GET, 32'hFFFF_FFFF, $urandom);
    queue_req(lrukv_pkg::OP_PUT, 32'h0000_0000, 32'hA5A5_A5A5);
    queue_req(lrukv_pkg::OP_GET, 32'h0000_0000, $urandom);
    queue_req(lrukv_pkg::OP_GET, 32'h0000_0002, $urandom);
    queue_req(lrukv_pkg::OP_GET, 32'hFFFF_FFFE, $urandom);
    queue_req(lrukv_pkg::OP_PUT, 32'h0000_0001, 32'h5A5A_5A5A);
    queue_req(lrukv_pkg::OP_GET, 32'h0000_0001, $urandom);
    wait_idle();

    write_capacity(5'd0);
    set_idling(76, 0);
    queue_random(60, 3);
    wait_idle();

    write_capacity(5'd31);
    set_idling(0, 76);
    queue_random(130, 24);
    wait_idle();

    write_capacity(5'd4);
    set_idling(11, 11);
    queue_random(130, 8);
    wait_idle();

    // fill every slot, then hold the receiver off while gets keep coming
    write_capacity(5'd16);
    set_idling(0, 0);
    for (int i = 0; i < SLOTS; i++) queue_req(lrukv_pkg::OP_PUT, $urandom, $urandom);
    queue_random(130, 20);
    @(posedge clk);
    hold_kick <= 1'b1;
    @(posedge clk);
    hold_kick <= 1'b0;
    wait_idle();

    write_capacity(5'd3);
    set_idling(11, 11);
    queue_random(130, 20);
    wait_idle();

    write_capacity(5'd1);
    set_idling(0, 0);
    queue_req(lrukv_pkg::OP_PUT, 32'h0000_0AAA, 32'h0000_0111);
    queue_req(lrukv_pkg::OP_PUT, 32'h0000_0BBB, 32'h0000_0222);
    queue_req(lrukv_pkg::OP_GET, 32'h0000_0AAA, $urandom);
    queue_req(lrukv_pkg::OP_GET, 32'h0000_0BBB, $urandom);
    queue_random(60, 4);
    wait_idle();

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/lrukv_pkg.sv
sv/lrukv_cell.sv
sv/lru_cache_key_value_store_unit.sv
sv/lrukv_checker.sv
tb/tb.sv
